// File: rtl/sdc_pkg.sv
`default_nettype none

package sdc_pkg;

    // field widths
    localparam int LS_W     = 13;
    localparam int RS_W     = 14;
    localparam int POT_W    = 12;
    localparam int YAW_W    = 16;
    localparam int SPD_W    = 16;
    localparam int TGT_W    = 8;
    localparam int DUTY_W   = 11;

    // configuration register widths
    localparam int GAIN8_W  = 8;
    localparam int LOST_W   = 14;
    localparam int SGAIN_W  = 4;
    localparam int LIM_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    // internal widths
    localparam int ERR_W    = 15;   // line imbalance
    localparam int YE_W     = 27;   // yaw error
    localparam int YQ_W     = 13;   // |yaw| / 7
    localparam int CMD_W    = 9;    // signed motor command
    localparam int CORR_W   = 8;    // clamped steering correction
    localparam int OPA_W    = 27;
    localparam int OPB_W    = 18;
    localparam int ACC_W    = 34;

    // configuration reset values
    localparam int RST_STEER_KP   = 20;
    localparam int RST_STEER_KD   = 30;
    localparam int RST_LOST_SUM   = 2300;
    localparam int RST_POT_CENTER = 2100;
    localparam int RST_END_ANGLE  = 1250;
    localparam int RST_SPEED_GAIN = 4;
    localparam int RST_DRV_LIMIT  = 150;

    // control constants
    localparam int LIMIT_MAX      = 200;
    localparam int DUTY_MAX       = 1199;
    localparam int STEER_CLAMP    = 120;
    localparam int STEER_PUSH     = 20;
    localparam int STEER_SHIFT    = 6;    // divide by 64
    localparam int YAW_SHIFT      = 7;    // divide by 128
    localparam int YAW_GAIN       = 10;
    localparam int YAW_GAIN2      = 2 * YAW_GAIN;
    localparam int YAW_RECIP_SHIFT = 18;
    // ceil(2^18 / 7): exact quotient for magnitudes up to 2^15
    localparam int YAW_RECIP      = ((1 << YAW_RECIP_SHIFT) + 6) / 7;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEER_KP    = 3'd0,
        CFG_STEER_KD    = 3'd1,
        CFG_LOST_SUM    = 3'd2,
        CFG_POT_CENTER  = 3'd3,
        CFG_END_ANGLE   = 3'd4,
        CFG_SPEED_GAIN  = 3'd5,
        CFG_DRIVE_LIMIT = 3'd6
    } t_cfg_idx;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KP,
        ST_KD,
        ST_YAW,
        ST_TURN,
        ST_YE,
        ST_YNUM,
        ST_PRIOR,
        ST_SPD,
        ST_HEAD,
        ST_CMD
    } t_state;

    // multiplier operand selection
    typedef enum logic [2:0] {
        OP_KP,
        OP_KD,
        OP_YAW,
        OP_TURN,
        OP_YE,
        OP_PRIOR,
        OP_SPD
    } t_opsel;

    typedef struct packed {
        logic en;
        logic accum;
    } t_mac_cmd;

    typedef struct packed {
        logic     in_ready;
        t_mac_cmd mac;
        t_opsel   opsel;
        logic     ld_line;
        logic     ld_corr;
        logic     ld_steer;
        logic     ld_yq;
        logic     ld_ye;
        logic     ld_y;
        logic     ld_accel;
        logic     ld_out;
    } t_ctrl;

endpackage

`default_nettype wire

// File: rtl/sdc_if.sv
`default_nettype none

// control tick channel
interface sdc_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [sdc_pkg::LS_W-1:0]    left_sense;
    logic signed [sdc_pkg::RS_W-1:0]    right_sense;
    logic        [sdc_pkg::POT_W-1:0]   wheel_pot;
    logic signed [sdc_pkg::YAW_W-1:0]   yaw_rate;
    logic signed [sdc_pkg::SPD_W-1:0]   wheel_speed;
    logic        [sdc_pkg::TGT_W-1:0]   target_speed;
    logic                               motors_enabled;
    logic                               sensors_on;
    logic                               drive_run;

    modport source (
        output valid, left_sense, right_sense, wheel_pot, yaw_rate, wheel_speed,
               target_speed, motors_enabled, sensors_on, drive_run,
        input  ready
    );
    modport sink (
        input  valid, left_sense, right_sense, wheel_pot, yaw_rate, wheel_speed,
               target_speed, motors_enabled, sensors_on, drive_run,
        output ready
    );
endinterface

// motor command channel
interface sdc_out_if;
    logic                               valid;
    logic                               ready;
    logic [sdc_pkg::DUTY_W-1:0]         left_drive_duty;
    logic                               left_drive_reverse;
    logic [sdc_pkg::DUTY_W-1:0]         right_drive_duty;
    logic                               right_drive_forward_pin;
    logic [sdc_pkg::DUTY_W-1:0]         steer_duty;
    logic                               steer_reverse;

    modport source (
        output valid, left_drive_duty, left_drive_reverse, right_drive_duty,
               right_drive_forward_pin, steer_duty, steer_reverse,
        input  ready
    );
    modport sink (
        input  valid, left_drive_duty, left_drive_reverse, right_drive_duty,
               right_drive_forward_pin, steer_duty, steer_reverse,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/sdc_mac.sv
`default_nettype none

module sdc_mac (
    input  wire logic                                i_clk,
    input  wire sdc_pkg::t_mac_cmd                   i_cmd,
    input  wire logic signed [sdc_pkg::OPA_W-1:0]    i_op_a,
    input  wire logic signed [sdc_pkg::OPB_W-1:0]    i_op_b,
    output      logic signed [sdc_pkg::ACC_W-1:0]    o_acc
);

    logic signed [sdc_pkg::OPA_W+sdc_pkg::OPB_W-1:0] prod;
    logic signed [sdc_pkg::ACC_W-1:0]                r_acc;
    logic signed [sdc_pkg::ACC_W-1:0]                n_acc;

    // signed product, added to the running sum or loaded fresh
    assign prod = i_op_a * i_op_b;

    always_comb begin
        n_acc = (i_cmd.accum ? r_acc : '0) + sdc_pkg::ACC_W'(prod);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

// File: rtl/sdc_ctrl.sv
`default_nettype none

module sdc_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_fire,
    input  wire logic            i_out_stall,
    output      sdc_pkg::t_ctrl  o_ctrl
);

    sdc_pkg::t_state r_state;
    sdc_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sdc_pkg::ST_IDLE:  if (i_in_fire) n_state = sdc_pkg::ST_KP;
            sdc_pkg::ST_KP:    n_state = sdc_pkg::ST_KD;
            sdc_pkg::ST_KD:    n_state = sdc_pkg::ST_YAW;
            sdc_pkg::ST_YAW:   n_state = sdc_pkg::ST_TURN;
            sdc_pkg::ST_TURN:  n_state = sdc_pkg::ST_YE;
            sdc_pkg::ST_YE:    n_state = sdc_pkg::ST_YNUM;
            sdc_pkg::ST_YNUM:  n_state = sdc_pkg::ST_PRIOR;
            sdc_pkg::ST_PRIOR: n_state = sdc_pkg::ST_SPD;
            sdc_pkg::ST_SPD:   n_state = sdc_pkg::ST_HEAD;
            sdc_pkg::ST_HEAD:  n_state = sdc_pkg::ST_CMD;
            sdc_pkg::ST_CMD:   if (!i_out_stall) n_state = sdc_pkg::ST_IDLE;
            default:           n_state = sdc_pkg::ST_IDLE;
        endcase
    end

    // per-state strobes and multiplier commands
    always_comb begin
        o_ctrl = '0;
        o_ctrl.opsel = sdc_pkg::OP_KP;
        unique case (r_state)
            sdc_pkg::ST_IDLE: begin
                o_ctrl.in_ready = 1'b1;
            end
            sdc_pkg::ST_KP: begin
                o_ctrl.mac.en = 1'b1;
                o_ctrl.opsel  = sdc_pkg::OP_KP;
            end
            sdc_pkg::ST_KD: begin
                o_ctrl.mac.en    = 1'b1;
                o_ctrl.mac.accum = 1'b1;
                o_ctrl.opsel     = sdc_pkg::OP_KD;
                o_ctrl.ld_line   = 1'b1;
            end
            sdc_pkg::ST_YAW: begin
                o_ctrl.mac.en  = 1'b1;
                o_ctrl.opsel   = sdc_pkg::OP_YAW;
                o_ctrl.ld_corr = 1'b1;
            end
            sdc_pkg::ST_TURN: begin
                o_ctrl.mac.en   = 1'b1;
                o_ctrl.opsel    = sdc_pkg::OP_TURN;
                o_ctrl.ld_steer = 1'b1;
                o_ctrl.ld_yq    = 1'b1;
            end
            sdc_pkg::ST_YE: begin
                o_ctrl.ld_ye = 1'b1;
            end
            sdc_pkg::ST_YNUM: begin
                o_ctrl.mac.en = 1'b1;
                o_ctrl.opsel  = sdc_pkg::OP_YE;
            end
            sdc_pkg::ST_PRIOR: begin
                o_ctrl.mac.en    = 1'b1;
                o_ctrl.mac.accum = 1'b1;
                o_ctrl.opsel     = sdc_pkg::OP_PRIOR;
            end
            sdc_pkg::ST_SPD: begin
                o_ctrl.mac.en = 1'b1;
                o_ctrl.opsel  = sdc_pkg::OP_SPD;
                o_ctrl.ld_y   = 1'b1;
            end
            sdc_pkg::ST_HEAD: begin
                o_ctrl.ld_accel = 1'b1;
            end
            sdc_pkg::ST_CMD: begin
                o_ctrl.ld_out = !i_out_stall;
            end
            default: begin
                o_ctrl.in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/steering_and_drive_controller.sv
// Steering and drive controller. Each accepted item is one control tick; it
// yields exactly one item of motor commands (left drive, right drive and
// steering duty with direction bits). The arithmetic runs through a single
// shared 27x18 signed multiply-accumulate unit stepped by a sequencer with
// an idle state and ten working steps. A new item is taken only once the
// sequencer is back in idle, and the output register is loaded in the last
// step. The input ready is high only while the sequencer idles; a finished
// result waits in the output register without holding up the next item,
// and the sequencer stalls in its last step only when a second result would
// overwrite one not yet taken. The user must write configuration registers
// through the write port only while no item is in flight; the block does
// not enforce this. Indexes beyond the last register are ignored.

`default_nettype none

module steering_and_drive_controller (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    sdc_in_if.sink                                     i_in,
    sdc_out_if.source                                  o_out,
    input  wire logic                                  i_cfg_wr_en,
    input  wire logic [sdc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [sdc_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int ACC_W = sdc_pkg::ACC_W;
    localparam int CMD_W = sdc_pkg::CMD_W;
    localparam int LIM_W = sdc_pkg::LIM_W;

    // clamp a command to +-lim
    function automatic logic signed [CMD_W-1:0] clamp_cmd(
        input logic signed [CMD_W:0] v,
        input logic [LIM_W-1:0]      lim
    );
        logic signed [CMD_W:0] lim_s;
        lim_s = $signed((CMD_W + 1)'(lim));
        if (v > lim_s) begin
            clamp_cmd = CMD_W'(lim_s);
        end else if (v < -lim_s) begin
            clamp_cmd = CMD_W'(-lim_s);
        end else begin
            clamp_cmd = CMD_W'(v);
        end
    endfunction

    // magnitude of a command
    function automatic logic [LIM_W-1:0] mag_cmd(input logic signed [CMD_W-1:0] v);
        logic signed [CMD_W-1:0] neg;
        neg = -v;
        mag_cmd = v[CMD_W-1] ? LIM_W'(neg) : LIM_W'(v);
    endfunction

    // 1199*a/200 truncated equals 6a-1 for 1 <= a <= 200
    function automatic logic [sdc_pkg::DUTY_W-1:0] duty_of(input logic [LIM_W-1:0] a);
        logic [sdc_pkg::DUTY_W-1:0] a_w;
        a_w = sdc_pkg::DUTY_W'(a);
        duty_of = (a == '0) ? '0 : (a_w << 2) + (a_w << 1) - sdc_pkg::DUTY_W'(1);
    endfunction

    sdc_pkg::t_ctrl ctrl;
    logic in_fire;
    logic out_stall;

    // configuration registers
    logic [sdc_pkg::GAIN8_W-1:0]  r_steer_kp;
    logic [sdc_pkg::GAIN8_W-1:0]  r_steer_kd;
    logic [sdc_pkg::LOST_W-1:0]   r_line_lost_sum;
    logic [sdc_pkg::POT_W-1:0]    r_pot_center;
    logic [sdc_pkg::POT_W-1:0]    r_steer_end_angle;
    logic [sdc_pkg::SGAIN_W-1:0]  r_speed_gain;
    logic [LIM_W-1:0]             r_drive_limit;

    // captured item
    logic signed [sdc_pkg::LS_W-1:0]   r_left;
    logic signed [sdc_pkg::RS_W-1:0]   r_right;
    logic        [sdc_pkg::POT_W-1:0]  r_pot;
    logic signed [sdc_pkg::YAW_W-1:0]  r_yaw;
    logic signed [sdc_pkg::SPD_W-1:0]  r_spd;
    logic        [sdc_pkg::TGT_W-1:0]  r_tgt;
    logic                              r_men;
    logic                              r_son;
    logic                              r_run;

    // loop state and intermediates
    logic signed [sdc_pkg::ERR_W-1:0]  r_prior_line;
    logic signed [sdc_pkg::YE_W-1:0]   r_prior_yaw;
    logic signed [CMD_W-1:0]           r_steer;
    logic signed [sdc_pkg::CORR_W-1:0] r_corr;
    logic signed [sdc_pkg::YQ_W:0]     r_yq;
    logic signed [sdc_pkg::YE_W-1:0]   r_ye;
    logic signed [CMD_W-1:0]           r_y;
    logic signed [CMD_W-1:0]           r_accel;

    // output register
    logic                              r_out_valid;
    logic [sdc_pkg::DUTY_W-1:0]        r_left_duty;
    logic                              r_left_rev;
    logic [sdc_pkg::DUTY_W-1:0]        r_right_duty;
    logic                              r_right_fwd;
    logic [sdc_pkg::DUTY_W-1:0]        r_steer_duty;
    logic                              r_steer_rev;

    logic signed [sdc_pkg::OPA_W-1:0]  op_a;
    logic signed [sdc_pkg::OPB_W-1:0]  op_b;
    logic signed [ACC_W-1:0]           acc;

    logic [LIM_W-1:0]                  lim;
    logic signed [sdc_pkg::ERR_W-1:0]  line_e;
    logic signed [sdc_pkg::ERR_W:0]    line_d;
    logic signed [sdc_pkg::ERR_W-1:0]  line_sum;
    logic                              line_lost;
    logic signed [sdc_pkg::POT_W:0]    angle;
    logic signed [sdc_pkg::POT_W:0]    angle_bias;
    logic signed [sdc_pkg::POT_W:0]    angle_half;
    logic signed [sdc_pkg::POT_W-1:0]  turn;
    logic signed [sdc_pkg::POT_W+1:0]  angle_x;
    logic signed [sdc_pkg::POT_W+1:0]  end_x;
    logic                              at_pos_end;
    logic                              at_neg_end;
    logic signed [sdc_pkg::YAW_W:0]    yaw_x;
    logic        [sdc_pkg::YAW_W:0]    yaw_mag;
    logic signed [sdc_pkg::SPD_W:0]    spd_err;

    logic signed [ACC_W-1:0]           c_bias;
    logic signed [ACC_W-1:0]           c_q;
    logic signed [sdc_pkg::CORR_W-1:0] corr;
    logic [sdc_pkg::YQ_W-1:0]          yq_mag;
    logic signed [sdc_pkg::YQ_W:0]     yq;
    logic signed [sdc_pkg::YE_W:0]     ye_wide;
    logic signed [ACC_W-1:0]           y_bias;
    logic signed [ACC_W-1:0]           y_q;
    logic signed [ACC_W-1:0]           lim_acc;
    logic signed [CMD_W-1:0]           y_cl;
    logic [LIM_W-1:0]                  head;
    logic signed [ACC_W-1:0]           head_acc;
    logic signed [CMD_W-1:0]           accel;
    logic signed [CMD_W:0]             r_sum;
    logic signed [CMD_W:0]             l_sum;
    logic signed [CMD_W-1:0]           rcmd;
    logic signed [CMD_W-1:0]           lcmd;
    logic signed [CMD_W-1:0]           scmd;

    assign in_fire   = i_in.valid && i_in.ready;
    assign out_stall = r_out_valid && !o_out.ready;

    sdc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_fire   (in_fire),
        .i_out_stall (out_stall),
        .o_ctrl      (ctrl)
    );

    sdc_mac u_mac (
        .i_clk  (i_clk),
        .i_cmd  (ctrl.mac),
        .i_op_a (op_a),
        .i_op_b (op_b),
        .o_acc  (acc)
    );

    assign i_in.ready = ctrl.in_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steer_kp        <= sdc_pkg::GAIN8_W'(sdc_pkg::RST_STEER_KP);
            r_steer_kd        <= sdc_pkg::GAIN8_W'(sdc_pkg::RST_STEER_KD);
            r_line_lost_sum   <= sdc_pkg::LOST_W'(sdc_pkg::RST_LOST_SUM);
            r_pot_center      <= sdc_pkg::POT_W'(sdc_pkg::RST_POT_CENTER);
            r_steer_end_angle <= sdc_pkg::POT_W'(sdc_pkg::RST_END_ANGLE);
            r_speed_gain      <= sdc_pkg::SGAIN_W'(sdc_pkg::RST_SPEED_GAIN);
            r_drive_limit     <= LIM_W'(sdc_pkg::RST_DRV_LIMIT);
        end else if (i_cfg_wr_en) begin
            unique case (sdc_pkg::t_cfg_idx'(i_cfg_index))
                sdc_pkg::CFG_STEER_KP:    r_steer_kp <= sdc_pkg::GAIN8_W'(i_cfg_data);
                sdc_pkg::CFG_STEER_KD:    r_steer_kd <= sdc_pkg::GAIN8_W'(i_cfg_data);
                sdc_pkg::CFG_LOST_SUM:    r_line_lost_sum <= i_cfg_data;
                sdc_pkg::CFG_POT_CENTER:  r_pot_center <= sdc_pkg::POT_W'(i_cfg_data);
                sdc_pkg::CFG_END_ANGLE:   r_steer_end_angle <= sdc_pkg::POT_W'(i_cfg_data);
                sdc_pkg::CFG_SPEED_GAIN:  r_speed_gain <= sdc_pkg::SGAIN_W'(i_cfg_data);
                sdc_pkg::CFG_DRIVE_LIMIT: r_drive_limit <= LIM_W'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_left  <= i_in.left_sense;
            r_right <= i_in.right_sense;
            r_pot   <= i_in.wheel_pot;
            r_yaw   <= i_in.yaw_rate;
            r_spd   <= i_in.wheel_speed;
            r_tgt   <= i_in.target_speed;
            r_men   <= i_in.motors_enabled;
            r_son   <= i_in.sensors_on;
            r_run   <= i_in.drive_run;
        end
    end

    // terms taken straight from the captured item
    always_comb begin
        lim = (r_drive_limit > LIM_W'(sdc_pkg::LIMIT_MAX)) ?
              LIM_W'(sdc_pkg::LIMIT_MAX) : r_drive_limit;
        line_e    = sdc_pkg::ERR_W'(r_left) - sdc_pkg::ERR_W'(r_right);
        line_d    = (sdc_pkg::ERR_W + 1)'(line_e) - (sdc_pkg::ERR_W + 1)'(r_prior_line);
        line_sum  = sdc_pkg::ERR_W'(r_left) + sdc_pkg::ERR_W'(r_right);
        line_lost = line_sum >= $signed(sdc_pkg::ERR_W'(r_line_lost_sum));
        angle      = $signed((sdc_pkg::POT_W + 1)'(r_pot))
                   - $signed((sdc_pkg::POT_W + 1)'(r_pot_center));
        // half angle, rounded toward zero
        angle_bias = angle + $signed((sdc_pkg::POT_W + 1)'(angle[sdc_pkg::POT_W]));
        angle_half = angle_bias >>> 1;
        turn       = sdc_pkg::POT_W'(-angle_half);
        angle_x    = (sdc_pkg::POT_W + 2)'(angle);
        end_x      = $signed((sdc_pkg::POT_W + 2)'(r_steer_end_angle));
        at_pos_end = angle_x >= end_x;
        at_neg_end = angle_x <= -end_x;
        yaw_x      = (sdc_pkg::YAW_W + 1)'(r_yaw);
        yaw_mag    = yaw_x[sdc_pkg::YAW_W] ? -yaw_x : yaw_x;
        spd_err    = (sdc_pkg::SPD_W + 1)'(r_spd) - $signed((sdc_pkg::SPD_W + 1)'(r_tgt));
    end

    // multiplier operand selection
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (ctrl.opsel)
            sdc_pkg::OP_KP: begin
                op_a = sdc_pkg::OPA_W'(line_e);
                op_b = sdc_pkg::OPB_W'(r_steer_kp);
            end
            sdc_pkg::OP_KD: begin
                op_a = sdc_pkg::OPA_W'(line_d);
                op_b = sdc_pkg::OPB_W'(r_steer_kd);
            end
            sdc_pkg::OP_YAW: begin
                op_a = sdc_pkg::OPA_W'(yaw_mag);
                op_b = sdc_pkg::OPB_W'(sdc_pkg::YAW_RECIP);
            end
            sdc_pkg::OP_TURN: begin
                op_a = sdc_pkg::OPA_W'(turn);
                op_b = sdc_pkg::OPB_W'(r_spd);
            end
            sdc_pkg::OP_YE: begin
                op_a = r_ye;
                op_b = sdc_pkg::OPB_W'(sdc_pkg::YAW_GAIN2);
            end
            sdc_pkg::OP_PRIOR: begin
                op_a = r_prior_yaw;
                op_b = sdc_pkg::OPB_W'(-sdc_pkg::YAW_GAIN);
            end
            sdc_pkg::OP_SPD: begin
                op_a = sdc_pkg::OPA_W'(spd_err);
                op_b = sdc_pkg::OPB_W'(r_speed_gain);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // steering correction: sum / 64 toward zero, clamp, zero when line lost
    always_comb begin
        c_bias = acc + $signed(ACC_W'({sdc_pkg::STEER_SHIFT{acc[ACC_W-1]}}));
        c_q    = c_bias >>> sdc_pkg::STEER_SHIFT;
        if (line_lost) begin
            corr = '0;
        end else if (c_q > ACC_W'(sdc_pkg::STEER_CLAMP)) begin
            corr = sdc_pkg::CORR_W'(sdc_pkg::STEER_CLAMP);
        end else if (c_q < ACC_W'(-sdc_pkg::STEER_CLAMP)) begin
            corr = sdc_pkg::CORR_W'(-sdc_pkg::STEER_CLAMP);
        end else begin
            corr = sdc_pkg::CORR_W'(c_q);
        end
    end

    // yaw error: |yaw| / 7 by reciprocal with sign restored, held while the
    // unit forms turn * speed, then the product is subtracted
    always_comb begin
        yq_mag  = acc[sdc_pkg::YAW_RECIP_SHIFT +: sdc_pkg::YQ_W];
        yq      = r_yaw[sdc_pkg::YAW_W-1] ? -$signed((sdc_pkg::YQ_W + 1)'(yq_mag))
                                          : $signed((sdc_pkg::YQ_W + 1)'(yq_mag));
        ye_wide = (sdc_pkg::YE_W + 1)'(r_yq) - (sdc_pkg::YE_W + 1)'(acc);
    end

    // yaw term: numerator / 128 toward zero, clamped to the limit
    always_comb begin
        y_bias  = acc + $signed(ACC_W'({sdc_pkg::YAW_SHIFT{acc[ACC_W-1]}}));
        y_q     = y_bias >>> sdc_pkg::YAW_SHIFT;
        lim_acc = $signed(ACC_W'(lim));
        if (y_q > lim_acc) begin
            y_cl = CMD_W'(lim_acc);
        end else if (y_q < -lim_acc) begin
            y_cl = CMD_W'(-lim_acc);
        end else begin
            y_cl = CMD_W'(y_q);
        end
    end

    // speed term limited by the headroom left by the yaw term, zero when the target speed is zero
    always_comb begin
        head     = lim - mag_cmd(r_y);
        head_acc = $signed(ACC_W'(head));
        if (r_tgt == '0) begin
            accel = '0;
        end else if (acc > head_acc) begin
            accel = CMD_W'(head_acc);
        end else if (acc < -head_acc) begin
            accel = CMD_W'(-head_acc);
        end else begin
            accel = CMD_W'(acc);
        end
    end

    // final commands
    always_comb begin
        r_sum = (CMD_W + 1)'(r_y) + (CMD_W + 1)'(r_accel);
        l_sum = (CMD_W + 1)'(r_accel) - (CMD_W + 1)'(r_y);
        rcmd  = (r_run && r_men) ? clamp_cmd(r_sum, lim) : '0;
        lcmd  = (r_run && r_men) ? clamp_cmd(l_sum, lim) : '0;
        scmd  = r_men ? clamp_cmd((CMD_W + 1)'(r_steer), lim) : '0;
    end

    // loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior_line <= '0;
            r_prior_yaw  <= '0;
            r_steer      <= '0;
        end else begin
            if (ctrl.ld_line) begin
                r_prior_line <= line_e;
            end
            if (ctrl.ld_steer && r_men && r_son) begin
                if (at_pos_end) begin
                    r_steer <= CMD_W'(sdc_pkg::STEER_PUSH);
                end else if (at_neg_end) begin
                    r_steer <= CMD_W'(-sdc_pkg::STEER_PUSH);
                end else begin
                    r_steer <= CMD_W'(r_corr);
                end
            end else if (ctrl.ld_out) begin
                r_steer <= scmd;
            end
            if (ctrl.ld_out && r_run) begin
                r_prior_yaw <= r_ye;
            end
        end
    end

    // intermediates
    always_ff @(posedge i_clk) begin
        if (ctrl.ld_corr) begin
            r_corr <= corr;
        end
        if (ctrl.ld_yq) begin
            r_yq <= yq;
        end
        if (ctrl.ld_ye) begin
            r_ye <= sdc_pkg::YE_W'(ye_wide);
        end
        if (ctrl.ld_y) begin
            r_y <= y_cl;
        end
        if (ctrl.ld_accel) begin
            r_accel <= accel;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.ld_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.ld_out) begin
            r_left_duty  <= duty_of(mag_cmd(lcmd));
            r_left_rev   <= lcmd[CMD_W-1];
            r_right_duty <= duty_of(mag_cmd(rcmd));
            r_right_fwd  <= !rcmd[CMD_W-1];
            r_steer_duty <= duty_of(mag_cmd(scmd));
            r_steer_rev  <= scmd[CMD_W-1];
        end
    end

    assign o_out.valid                   = r_out_valid;
    assign o_out.left_drive_duty         = r_left_duty;
    assign o_out.left_drive_reverse      = r_left_rev;
    assign o_out.right_drive_duty        = r_right_duty;
    assign o_out.right_drive_forward_pin = r_right_fwd;
    assign o_out.steer_duty              = r_steer_duty;
    assign o_out.steer_reverse           = r_steer_rev;

endmodule

`default_nettype wire

// File: rtl/sdc_checker.sv
`default_nettype none

module sdc_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_in_valid,
    input wire logic                             i_in_ready,
    input wire logic                             i_out_valid,
    input wire logic                             i_out_ready,
    input wire logic [sdc_pkg::DUTY_W-1:0]       i_left_duty,
    input wire logic                             i_left_rev,
    input wire logic [sdc_pkg::DUTY_W-1:0]       i_right_duty,
    input wire logic                             i_right_fwd,
    input wire logic [sdc_pkg::DUTY_W-1:0]       i_steer_duty,
    input wire logic                             i_steer_rev
);

    // an accepted item keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after an accepted item");

    // a fresh result only comes out of a busy cycle
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared without work in progress");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_left_duty)
            && $stable(i_right_duty) && $stable(i_steer_duty) && $stable(i_left_rev)
            && $stable(i_right_fwd) && $stable(i_steer_rev)))
        else $error("stalled result changed");

    // duty stays within full scale
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_left_duty <= sdc_pkg::DUTY_W'(sdc_pkg::DUTY_MAX)
            && i_right_duty <= sdc_pkg::DUTY_W'(sdc_pkg::DUTY_MAX)
            && i_steer_duty <= sdc_pkg::DUTY_W'(sdc_pkg::DUTY_MAX)))
        else $error("duty above full scale");

    // a negative command never has zero duty
    a_sign_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((!i_left_rev || i_left_duty != '0)
            && (i_right_fwd || i_right_duty != '0)
            && (!i_steer_rev || i_steer_duty != '0)))
        else $error("reverse direction with zero duty");

endmodule

bind steering_and_drive_controller sdc_checker u_sdc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_left_duty  (o_out.left_drive_duty),
    .i_left_rev   (o_out.left_drive_reverse),
    .i_right_duty (o_out.right_drive_duty),
    .i_right_fwd  (o_out.right_drive_forward_pin),
    .i_steer_duty (o_out.steer_duty),
    .i_steer_rev  (o_out.steer_reverse)
);

`default_nettype wire
